// ===== design/tclc_pkg.sv =====
`timescale 1ns / 1ps

package tclc_pkg;

  // sample and register widths
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned GAIN_W     = 7;
  localparam int unsigned TIME_W     = 4;
  localparam int unsigned PKG_W      = 16;
  localparam int unsigned GT_W       = GAIN_W + TIME_W;
  localparam int unsigned DEN_W      = GT_W + PKG_W;
  localparam int unsigned LUX_W      = 27;
  localparam int unsigned REGION_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // formula value is scaled by 2^17 before the divide
  localparam int unsigned OUT_SCALE_SHIFT = 17;
  // dividend after folding the coefficient fraction bits into it
  localparam int unsigned NUM_W = 3 + CNT_W + 1 + OUT_SCALE_SHIFT + 1;

  localparam int unsigned DEFAULT_COEF_FRAC_BITS = 14;

  // ratio test by cross-multiplication, cutoffs in hundredths
  localparam int unsigned RATIO_W     = CNT_W + 1 + 7;
  localparam int unsigned RATIO_SCALE = 100;
  localparam int unsigned CUT_LOW     = 45;
  localparam int unsigned CUT_MID     = 64;
  localparam int unsigned CUT_HIGH    = 85;

  // coefficients in units of 1e-4
  localparam longint unsigned K_LOW_C0  = 17743;
  localparam longint unsigned K_LOW_C1  = 11059;
  localparam longint unsigned K_MID_C0  = 42785;
  localparam longint unsigned K_MID_C1  = 19548;
  localparam longint unsigned K_HIGH_C0 = 5926;
  localparam longint unsigned K_HIGH_C1 = 1185;

  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PKG  = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd1;
  localparam logic [TIME_W-1:0] TIME_RESET = 4'd2;
  localparam logic [PKG_W-1:0]  PKG_RESET  = 16'd256;

  typedef enum logic [REGION_W-1:0] {
    REGION_LOW  = 3'd0,
    REGION_MID  = 3'd1,
    REGION_HIGH = 3'd2,
    REGION_CLIP = 3'd3,
    REGION_DARK = 3'd4
  } region_t;

  // one classified sample waiting for its divide
  typedef struct packed {
    region_t          region;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } job_t;

  // round-to-nearest fixed point coefficient from a value in 1e-4 units
  function automatic longint unsigned coef_q(input longint unsigned k_e4,
                                             input int unsigned frac_bits);
    return ((k_e4 << frac_bits) + 64'd5000) / 64'd10000;
  endfunction

endpackage

// ===== design/tclc_front.sv =====
`timescale 1ns / 1ps

module tclc_front #(
  parameter int unsigned COEF_FRAC_BITS = tclc_pkg::DEFAULT_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tclc_pkg::CNT_W-1:0]    visible_ir_count,
  input  logic [tclc_pkg::CNT_W-1:0]    ir_count,
  input  logic [tclc_pkg::GAIN_W-1:0]   gain_factor,
  input  logic [tclc_pkg::TIME_W-1:0]   int_time_halves,
  input  logic [tclc_pkg::PKG_W-1:0]    package_factor_q8,
  input  logic                          q_full,
  output logic                          push,
  output tclc_pkg::job_t                push_job
);

  localparam int unsigned COEF_W  = COEF_FRAC_BITS + 3;
  localparam int unsigned PROD_W  = COEF_W + tclc_pkg::CNT_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned SHIFT_W = SUM_W + tclc_pkg::OUT_SCALE_SHIFT;
  localparam int unsigned RW      = tclc_pkg::RATIO_W;

  localparam logic [COEF_W-1:0] C_LOW0  =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_LOW_C0, COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] C_LOW1  =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_LOW_C1, COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] C_MID0  =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_MID_C0, COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] C_MID1  =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_MID_C1, COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] C_HIGH0 =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_HIGH_C0, COEF_FRAC_BITS));
  localparam logic [COEF_W-1:0] C_HIGH1 =
    COEF_W'(tclc_pkg::coef_q(tclc_pkg::K_HIGH_C1, COEF_FRAC_BITS));

  logic                        adv;

  // classification
  logic [tclc_pkg::CNT_W:0]    sum;
  logic [RW-1:0]               lhs;
  logic [RW-1:0]               rhs_low;
  logic [RW-1:0]               rhs_mid;
  logic [RW-1:0]               rhs_high;
  tclc_pkg::region_t           region_next;

  // stage 1
  logic                        v1;
  logic [tclc_pkg::CNT_W-1:0]  c0_1;
  logic [tclc_pkg::CNT_W-1:0]  c1_1;
  tclc_pkg::region_t           region1;
  logic [tclc_pkg::GT_W-1:0]   gt1;
  logic [tclc_pkg::PKG_W-1:0]  pkg1;

  // stage 2
  logic [COEF_W-1:0]           ca;
  logic [COEF_W-1:0]           cb;
  logic                        v2;
  logic [PROD_W-1:0]           pa;
  logic [PROD_W-1:0]           pb;
  tclc_pkg::region_t           region2;
  logic [tclc_pkg::DEN_W-1:0]  den2;

  // stage 3
  logic [SUM_W-1:0]            s_next;
  logic                        v3;
  logic [SUM_W-1:0]            s3;
  tclc_pkg::region_t           region3;
  logic [tclc_pkg::DEN_W-1:0]  den3;
  logic [SHIFT_W-1:0]          scaled;

  assign adv  = !q_full;
  assign busy = q_full;

  assign sum      = {1'b0, visible_ir_count} + {1'b0, ir_count};
  assign lhs      = RW'(ir_count) * RW'(tclc_pkg::RATIO_SCALE);
  assign rhs_low  = RW'(sum) * RW'(tclc_pkg::CUT_LOW);
  assign rhs_mid  = RW'(sum) * RW'(tclc_pkg::CUT_MID);
  assign rhs_high = RW'(sum) * RW'(tclc_pkg::CUT_HIGH);

  always_comb begin
    priority if (sum == '0) begin
      region_next = tclc_pkg::REGION_DARK;
    end else if (lhs < rhs_low) begin
      region_next = tclc_pkg::REGION_LOW;
    end else if (lhs < rhs_mid) begin
      region_next = tclc_pkg::REGION_MID;
    end else if (lhs < rhs_high) begin
      region_next = tclc_pkg::REGION_HIGH;
    end else begin
      region_next = tclc_pkg::REGION_CLIP;
    end
  end

  // coefficient pair per region, zero where no formula applies
  always_comb begin
    unique case (region1)
      tclc_pkg::REGION_LOW: begin
        ca = C_LOW0;
        cb = C_LOW1;
      end
      tclc_pkg::REGION_MID: begin
        ca = C_MID0;
        cb = C_MID1;
      end
      tclc_pkg::REGION_HIGH: begin
        ca = C_HIGH0;
        cb = C_HIGH1;
      end
      default: begin
        ca = '0;
        cb = '0;
      end
    endcase
  end

  // mid formula subtracts and clamps at zero
  always_comb begin
    if (region2 == tclc_pkg::REGION_MID) begin
      s_next = (pa > pb) ? SUM_W'(pa - pb) : '0;
    end else begin
      s_next = SUM_W'(pa) + SUM_W'(pb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_1    <= visible_ir_count;
      c1_1    <= ir_count;
      region1 <= region_next;
      gt1     <= tclc_pkg::GT_W'(gain_factor) * tclc_pkg::GT_W'(int_time_halves);
      pkg1    <= package_factor_q8;

      pa      <= PROD_W'(ca) * PROD_W'(c0_1);
      pb      <= PROD_W'(cb) * PROD_W'(c1_1);
      region2 <= region1;
      den2    <= tclc_pkg::DEN_W'(gt1) * tclc_pkg::DEN_W'(pkg1);

      s3      <= s_next;
      region3 <= region2;
      den3    <= den2;
    end
  end

  // fold the 2^17 scale and the coefficient fraction bits into the dividend
  assign scaled = {s3, {tclc_pkg::OUT_SCALE_SHIFT{1'b0}}} >> COEF_FRAC_BITS;

  assign push            = v3 && !q_full;
  assign push_job.region = region3;
  assign push_job.num    = scaled[tclc_pkg::NUM_W-1:0];
  assign push_job.den    = den3;

endmodule

// ===== design/tclc_queue.sv =====
`timescale 1ns / 1ps

module tclc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tclc_pkg::job_t push_job,
  output logic           full,
  output logic           pop_valid,
  output tclc_pkg::job_t pop_job
);

  localparam int unsigned DEPTH = tclc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tclc_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full = (count == CNT_W'(DEPTH));
  assign pop  = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
    if (pop) begin
      pop_job <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      pop_valid <= 1'b0;
    end else begin
      pop_valid <= pop;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ===== design/tclc_back.sv =====
`timescale 1ns / 1ps

module tclc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  tclc_pkg::job_t               in_job,
  output logic                         done,
  output logic [tclc_pkg::LUX_W-1:0]   lux_q8,
  output logic [tclc_pkg::REGION_W-1:0] region
);

  localparam int unsigned DW = tclc_pkg::DEN_W;
  localparam int unsigned NW = tclc_pkg::NUM_W;
  localparam int unsigned HW = NW - DW;

  // one quotient bit per stage, stage 0 does the overflow check
  logic                v_s     [DW+1];
  logic [DW-1:0]       rem_s   [DW+1];
  logic [DW-1:0]       quo_s   [DW+1];
  logic [NW-1:0]       num_s   [DW+1];
  logic [DW-1:0]       den_s   [DW+1];
  logic                sat_s   [DW+1];
  tclc_pkg::region_t   reg_s   [DW+1];
  logic [DW:0]         trial_s [DW];
  logic                ge_s    [DW];
  logic [HW-1:0]       head;
  logic                no_formula;

  assign head = in_job.num[NW-1:DW];

  // trial subtract of each divide stage, from the previous stage's state
  always_comb begin
    for (int k = 1; k <= DW; k++) begin
      trial_s[k-1] = {rem_s[k-1], num_s[k-1][DW-k]};
      ge_s[k-1]    = (trial_s[k-1] >= {1'b0, den_s[k-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DW; k++) begin
        v_s[k] <= 1'b0;
      end
    end else begin
      v_s[0] <= in_valid;
      for (int k = 1; k <= DW; k++) begin
        v_s[k] <= v_s[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    // quotient would not fit (also a zero divisor)
    sat_s[0] <= (DW'(head) >= in_job.den);
    rem_s[0] <= DW'(head);
    quo_s[0] <= '0;
    num_s[0] <= in_job.num;
    den_s[0] <= in_job.den;
    reg_s[0] <= in_job.region;
    for (int k = 1; k <= DW; k++) begin
      rem_s[k] <= ge_s[k-1] ? DW'(trial_s[k-1] - {1'b0, den_s[k-1]})
                            : trial_s[k-1][DW-1:0];
      quo_s[k] <= {quo_s[k-1][DW-2:0], ge_s[k-1]};
      num_s[k] <= num_s[k-1];
      den_s[k] <= den_s[k-1];
      sat_s[k] <= sat_s[k-1];
      reg_s[k] <= reg_s[k-1];
    end
  end

  assign no_formula = (reg_s[DW] == tclc_pkg::REGION_CLIP) ||
                      (reg_s[DW] == tclc_pkg::REGION_DARK);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_s[DW];
    end
  end

  always_ff @(posedge clk) begin
    region <= reg_s[DW];
    if (no_formula) begin
      lux_q8 <= '0;
    end else if (sat_s[DW]) begin
      lux_q8 <= '1;
    end else begin
      lux_q8 <= tclc_pkg::LUX_W'(quo_s[DW]);
    end
  end

endmodule

// ===== design/two_channel_lux_calculator_top.sv =====
`timescale 1ns / 1ps

// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// sample in | visible_ir_count, ir_count                | beat when start && !busy
// result    | lux_q8, region                            | beat when done, one cycle
// config    | cfg_index, cfg_data                       | write when cfg_we
//
// one sample per cycle sustained; a sample passes 34 register stages on its
// way to done, the first loaded by the accepting edge (3 front stages,
// queue write and read, overflow check, one restoring divide stage per
// quotient bit, output register)
// rst is synchronous and active high; it clears all valid bits, the queue and
// loads the register reset values
// the receiver cannot stall; busy rises only if the queue between front and
// divider fills, which the divider never lets happen since it drains a beat
// every cycle

module two_channel_lux_calculator_top #(
  parameter int unsigned COEF_FRAC_BITS = tclc_pkg::DEFAULT_COEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tclc_pkg::CNT_W-1:0]      visible_ir_count,
  input  logic [tclc_pkg::CNT_W-1:0]      ir_count,
  input  logic                            cfg_we,
  input  logic [tclc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tclc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            done,
  output logic [tclc_pkg::LUX_W-1:0]      lux_q8,
  output logic [tclc_pkg::REGION_W-1:0]   region
);

  // configuration registers
  logic [tclc_pkg::GAIN_W-1:0] gain_factor;
  logic [tclc_pkg::TIME_W-1:0] int_time_halves;
  logic [tclc_pkg::PKG_W-1:0]  package_factor_q8;

  // front to queue
  logic           push;
  tclc_pkg::job_t push_job;
  logic           q_full;

  // queue to divider
  logic           pop_valid;
  tclc_pkg::job_t pop_job;

  // writes to an unlisted index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_factor       <= tclc_pkg::GAIN_RESET;
      int_time_halves   <= tclc_pkg::TIME_RESET;
      package_factor_q8 <= tclc_pkg::PKG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tclc_pkg::CFG_GAIN: gain_factor       <= cfg_data[tclc_pkg::GAIN_W-1:0];
        tclc_pkg::CFG_TIME: int_time_halves   <= cfg_data[tclc_pkg::TIME_W-1:0];
        tclc_pkg::CFG_PKG:  package_factor_q8 <= cfg_data[tclc_pkg::PKG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify by ratio, evaluate the formula, build dividend and divisor
  tclc_front #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .visible_ir_count  (visible_ir_count),
    .ir_count          (ir_count),
    .gain_factor       (gain_factor),
    .int_time_halves   (int_time_halves),
    .package_factor_q8 (package_factor_q8),
    .q_full            (q_full),
    .push              (push),
    .push_job          (push_job)
  );

  // short decoupling queue
  tclc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  // pipelined divide with saturation
  tclc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_job   (pop_job),
    .done     (done),
    .lux_q8   (lux_q8),
    .region   (region)
  );

endmodule

// ===== tb/sv/tb_two_channel_lux_calculator_top.sv =====
`timescale 1ns / 1ps

// self-checking bench for the two-channel lux calculator
module tb_two_channel_lux_calculator_top;

  // widths taken from the package
  localparam int unsigned CNT_W      = tclc_pkg::CNT_W;
  localparam int unsigned LUX_W      = tclc_pkg::LUX_W;
  localparam int unsigned REGION_W   = tclc_pkg::REGION_W;
  localparam int unsigned CFG_IDX_W  = tclc_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = tclc_pkg::CFG_DATA_W;
  localparam int unsigned GAIN_W     = tclc_pkg::GAIN_W;
  localparam int unsigned TIME_W     = tclc_pkg::TIME_W;
  localparam int unsigned PKG_W      = tclc_pkg::PKG_W;

  // coefficient fraction bits, kept at the block's default
  localparam int unsigned FRAC = 14;

  // Q3.14 coefficients, rounded to nearest from the four-decimal values
  localparam longint unsigned Q_LOW_C0  = 64'd29070;  // 1.7743
  localparam longint unsigned Q_LOW_C1  = 64'd18119;  // 1.1059
  localparam longint unsigned Q_MID_C0  = 64'd70099;  // 4.2785
  localparam longint unsigned Q_MID_C1  = 64'd32027;  // 1.9548
  localparam longint unsigned Q_HIGH_C0 = 64'd9709;   // 0.5926
  localparam longint unsigned Q_HIGH_C1 = 64'd1942;   // 0.1185

  localparam longint unsigned LUX_TOP = 64'd134217727;
  localparam logic [LUX_W-1:0] LUX_SAT = '1;

  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // final wait for stray beats, with margin over the pipeline depth
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam longint unsigned CYCLE_LIMIT = 64'd400000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 175;

  // one result beat as the block presents it
  typedef struct packed {
    logic [LUX_W-1:0]  lux;
    tclc_pkg::region_t region;
  } lux_beat_t;

  // one line of the directed table: a register write or a sample pair,
  // the latter with a hand-written result where one is obvious
  typedef struct packed {
    bit                   is_cfg;
    bit                   known;
    logic [CFG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     a;
    logic [CNT_W-1:0]     b;
    lux_beat_t            res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CNT_W-1:0]      visible_ir_count = '0;
  logic [CNT_W-1:0]      ir_count = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  done;
  logic [LUX_W-1:0]      lux_q8;
  logic [REGION_W-1:0]   region;

  // bench copy of the divisor registers, reset values to start with
  longint unsigned gain_q = 64'd1;
  longint unsigned time_q = 64'd2;
  longint unsigned pkg_q  = 64'd256;

  lux_beat_t       pending_lux[$];
  stim_row_t       dir_rows[$];
  lux_beat_t       got_want;
  int unsigned     errors = 0;
  longint unsigned cycles = 0;

  two_channel_lux_calculator_top #(
    .COEF_FRAC_BITS(FRAC)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .visible_ir_count(visible_ir_count),
    .ir_count(ir_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .lux_q8(lux_q8),
    .region(region)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // classify by cross-multiplying against the cutoffs in hundredths, pick
  // the linear formula, then one truncating divide by the register product
  function automatic lux_beat_t predict_lux(input logic [CNT_W-1:0] c0,
                                            input logic [CNT_W-1:0] c1);
    longint unsigned ch0;
    longint unsigned ch1;
    longint unsigned total;
    longint unsigned s;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned den;
    longint unsigned q;
    lux_beat_t r;
    ch0 = 64'(c0);
    ch1 = 64'(c1);
    total = ch0 + ch1;
    s = 0;
    r.lux = '0;
    if (total == 0) begin
      r.region = tclc_pkg::REGION_DARK;
    end else if (64'd100 * ch1 < 64'd45 * total) begin
      r.region = tclc_pkg::REGION_LOW;
      s = Q_LOW_C0 * ch0 + Q_LOW_C1 * ch1;
    end else if (64'd100 * ch1 < 64'd64 * total) begin
      r.region = tclc_pkg::REGION_MID;
      pos = Q_MID_C0 * ch0;
      neg = Q_MID_C1 * ch1;
      // mid formula clamps at zero rather than wrapping
      s = (pos > neg) ? pos - neg : 64'd0;
    end else if (64'd100 * ch1 < 64'd85 * total) begin
      r.region = tclc_pkg::REGION_HIGH;
      s = Q_HIGH_C0 * ch0 + Q_HIGH_C1 * ch1;
    end else begin
      r.region = tclc_pkg::REGION_CLIP;
    end
    if (r.region != tclc_pkg::REGION_DARK && r.region != tclc_pkg::REGION_CLIP) begin
      den = (gain_q * time_q * pkg_q) << FRAC;
      // any zero register means a zero divisor, which pins the output high
      if (den == 0) begin
        r.lux = LUX_SAT;
      end else begin
        q = (s << tclc_pkg::OUT_SCALE_SHIFT) / den;
        r.lux = (q > LUX_TOP) ? LUX_SAT : q[LUX_W-1:0];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------

  // sample checked against the predictor
  function automatic stim_row_t row_smp(input logic [CNT_W-1:0] a,
                                        input logic [CNT_W-1:0] b);
    stim_row_t r;
    r = '0;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  // sample with its result written out by hand
  function automatic stim_row_t row_chk(input logic [CNT_W-1:0] a,
                                        input logic [CNT_W-1:0] b,
                                        input logic [LUX_W-1:0] lux,
                                        input tclc_pkg::region_t rg);
    stim_row_t r;
    r = '0;
    r.known = 1'b1;
    r.a = a;
    r.b = b;
    r.res.lux = lux;
    r.res.region = rg;
    return r;
  endfunction

  // register write, data carried in the a column
  function automatic stim_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.a = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // offer one sample pair, hold it until the block takes the beat, then
  // queue the result it must produce
  task automatic send_pair(input logic [CNT_W-1:0] c0,
                           input logic [CNT_W-1:0] c1,
                           input bit known, input lux_beat_t res,
                           input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cfg_we <= 1'b0;
    visible_ir_count <= c0;
    ir_count <= c1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_lux.push_back(known ? res : predict_lux(c0, c1));
  endtask

  // one register write; the enable stays up so writes can follow back to
  // back, the next sample beat lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      tclc_pkg::CFG_GAIN: gain_q = 64'(data[GAIN_W-1:0]);
      tclc_pkg::CFG_TIME: time_q = 64'(data[TIME_W-1:0]);
      tclc_pkg::CFG_PKG:  pkg_q = 64'(data[PKG_W-1:0]);
      default: ;
    endcase
  endtask

  // stop offering samples, then wait until every beat has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_lux.size() != 0) @(posedge clk);
  endtask

  // register set for one random phase, the first few pinned to reset values and extremes;
  // bits above each field are junk that the block must drop
  task automatic load_phase_regs(input int unsigned ph);
    logic [CFG_DATA_W-1:0] gd;
    logic [CFG_DATA_W-1:0] td;
    logic [CFG_DATA_W-1:0] pd;
    gd = CFG_DATA_W'($urandom);
    td = CFG_DATA_W'($urandom);
    pd = CFG_DATA_W'($urandom);
    case (ph)
      0: begin
        gd[GAIN_W-1:0] = tclc_pkg::GAIN_RESET;
        td[TIME_W-1:0] = tclc_pkg::TIME_RESET;
        pd = tclc_pkg::PKG_RESET;
      end
      1: begin
        gd[GAIN_W-1:0] = 7'd96;
        td[TIME_W-1:0] = 4'd8;
        pd = 16'hffff;
      end
      2: begin
        gd[GAIN_W-1:0] = 7'd1;
        td[TIME_W-1:0] = 4'd1;
        pd = 16'h0001;
      end
      3: begin
        gd[GAIN_W-1:0] = 7'd127;
        td[TIME_W-1:0] = 4'd15;
        pd = 16'h0000;
      end
      default: begin
        if ($urandom_range(0, 9) < 8) begin
          case ($urandom_range(0, 5))
            0: gd[GAIN_W-1:0] = 7'd1;
            1: gd[GAIN_W-1:0] = 7'd2;
            2: gd[GAIN_W-1:0] = 7'd4;
            3: gd[GAIN_W-1:0] = 7'd8;
            4: gd[GAIN_W-1:0] = 7'd48;
            default: gd[GAIN_W-1:0] = 7'd96;
          endcase
        end else begin
          gd[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 127));
        end
        td[TIME_W-1:0] = ($urandom_range(0, 9) < 8) ? TIME_W'($urandom_range(1, 8))
                                                   : TIME_W'($urandom_range(0, 15));
        pd = ($urandom_range(0, 9) < 6) ? CFG_DATA_W'($urandom_range(64, 1024))
                                        : CFG_DATA_W'($urandom_range(0, 65535));
      end
    endcase
    write_reg(tclc_pkg::CFG_GAIN, gd);
    write_reg(tclc_pkg::CFG_TIME, td);
    write_reg(tclc_pkg::CFG_PKG, pd);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  // random sample pair, weighted toward the ratio cutoffs and the corners
  task automatic pick_pair(output logic [CNT_W-1:0] c0,
                           output logic [CNT_W-1:0] c1);
    int unsigned mode;
    int total;
    int cut;
    int c0i;
    int c1i;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      c0 = CNT_W'($urandom);
      c1 = CNT_W'($urandom);
    end else if (mode < 7) begin
      total = int'($urandom_range(1, 131070));
      case ($urandom_range(0, 2))
        0: cut = 45;
        1: cut = 64;
        default: cut = 85;
      endcase
      c1i = (total * cut) / 100 + int'($urandom_range(0, 2)) - 1;
      if (c1i < 0) c1i = 0;
      if (c1i > 65535) c1i = 65535;
      c0i = total - c1i;
      if (c0i < 0) c0i = 0;
      if (c0i > 65535) c0i = 65535;
      c0 = CNT_W'(c0i);
      c1 = CNT_W'(c1i);
    end else if (mode == 7) begin
      c0 = CNT_W'($urandom_range(0, 15));
      c1 = CNT_W'($urandom_range(0, 15));
    end else if (mode == 8) begin
      // one channel dark
      if ($urandom_range(0, 1)) begin
        c0 = '0;
        c1 = CNT_W'($urandom);
      end else begin
        c0 = CNT_W'($urandom);
        c1 = '0;
      end
    end else begin
      c0 = 16'hffff - CNT_W'($urandom_range(0, 255));
      c1 = 16'hffff - CNT_W'($urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // results cannot be held off, so every done cycle is a beat
  always @(posedge clk) begin
    if (!rst && $isunknown(done)) begin
      report_mismatch("done is unknown");
    end else if (!rst && done) begin
      if (pending_lux.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, lux %0d region %0d",
                                  lux_q8, region));
      end else begin
        got_want = pending_lux.pop_front();
        if (lux_q8 !== got_want.lux)
          report_mismatch($sformatf("lux_q8 got %0d want %0d", lux_q8, got_want.lux));
        if (region !== got_want.region)
          report_mismatch($sformatf("region got %0d want %0d", region, got_want.region));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_two_channel_lux_calculator_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  initial begin
    stim_row_t row;
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] c1;
    bit burst;
    int unsigned ph;
    int unsigned n;

    // reset registers: divisor is 512 << 14, so lux is the sum over 64
    dir_rows.push_back(row_chk(16'd0, 16'd0, '0, tclc_pkg::REGION_DARK));
    dir_rows.push_back(row_chk(16'd0, 16'hffff, '0, tclc_pkg::REGION_CLIP));
    dir_rows.push_back(row_smp(16'hffff, 16'd0));
    dir_rows.push_back(row_smp(16'hffff, 16'hffff));
    // ratio exactly on the low cutoff falls into the mid region
    dir_rows.push_back(row_smp(16'd55, 16'd45));
    dir_rows.push_back(row_smp(16'd56, 16'd44));
    // exactly on the mid cutoff, then just under it
    dir_rows.push_back(row_smp(16'd36, 16'd64));
    dir_rows.push_back(row_smp(16'd37, 16'd63));
    // ratio exactly on the top cutoff is already too high
    dir_rows.push_back(row_chk(16'd15, 16'd85, '0, tclc_pkg::REGION_CLIP));
    dir_rows.push_back(row_smp(16'd16, 16'd84));
    dir_rows.push_back(row_smp(16'd1, 16'd0));
    dir_rows.push_back(row_chk(16'd0, 16'd1, '0, tclc_pkg::REGION_CLIP));
    // zero gain: regions with a formula saturate, the others stay zero
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_GAIN, 16'h0000));
    dir_rows.push_back(row_chk(16'hffff, 16'd0, LUX_SAT, tclc_pkg::REGION_LOW));
    dir_rows.push_back(row_chk(16'd1, 16'd1, LUX_SAT, tclc_pkg::REGION_MID));
    dir_rows.push_back(row_chk(16'd30, 16'd70, LUX_SAT, tclc_pkg::REGION_HIGH));
    dir_rows.push_back(row_chk(16'd0, 16'd0, '0, tclc_pkg::REGION_DARK));
    // junk above the gain field must be dropped, then zero time
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_GAIN, 16'hff81));
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_TIME, 16'hfff0));
    dir_rows.push_back(row_chk(16'd100, 16'd1, LUX_SAT, tclc_pkg::REGION_LOW));
    // longest time with zero package factor
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_TIME, 16'h000f));
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_PKG, 16'h0000));
    dir_rows.push_back(row_chk(16'd100, 16'd1, LUX_SAT, tclc_pkg::REGION_LOW));
    // smallest package factor, then a write past the last register
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_PKG, 16'h0001));
    dir_rows.push_back(row_cfg(CFG_SPARE, 16'hffff));
    dir_rows.push_back(row_smp(16'hffff, 16'd0));
    dir_rows.push_back(row_smp(16'd2, 16'd1));
    // gain off the nominal list and the largest divisor
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_GAIN, 16'h007f));
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_PKG, 16'hffff));
    dir_rows.push_back(row_smp(16'hffff, 16'd0));
    dir_rows.push_back(row_smp(16'd1, 16'd0));
    dir_rows.push_back(row_cfg(tclc_pkg::CFG_GAIN, 16'h0030));
    dir_rows.push_back(row_smp(16'd40000, 16'd12000));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.idx, row.a);
      end else begin
        send_pair(row.a, row.b, row.known, row.res, pick_gap(1'b0));
      end
    end

    // random phases, each under its own register set
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      load_phase_regs(ph);
      burst = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // switch between idling and back-to-back stretches
        if (n % 25 == 0) burst = ($urandom_range(0, 9) < 3);
        pick_pair(c0, c1);
        send_pair(c0, c1, 1'b0, '0, pick_gap(burst));
      end
    end

    cfg_we <= 1'b0;
    wait_idle();
    // catch any stray beat after the last one expected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_two_channel_lux_calculator_top: done, clean");
    end else begin
      $display("tb_two_channel_lux_calculator_top: done, errors");
    end
    $finish;
  end

endmodule
